FILE: hw/rtl/assert_macros.svh
// Assertion macros, included by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IEM_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("assertion failed");
`define IEM_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("assertion failed");
`else
`define IEM_ASSERT(lbl, clk_s, rst_s, prop)
`define IEM_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

FILE: hw/rtl/iem_pkg.sv
// Types and constants of the I2C EEPROM master.
package iem_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd80;
    localparam logic [3:0] BYTE_BITS      = 4'd8;

    // byte segments of a transaction
    localparam logic [1:0] SEG_DEV  = 2'd0;
    localparam logic [1:0] SEG_MEM  = 2'd1;
    localparam logic [1:0] SEG_DATA = 2'd2;
    localparam logic [1:0] SEG_TAIL = 2'd3;

    typedef enum logic [3:0] {
        SUB_IDLE   = 4'd0,
        SUB_START1 = 4'd1,
        SUB_START2 = 4'd2,
        SUB_TXL    = 4'd3,
        SUB_TXH    = 4'd4,
        SUB_ACKL   = 4'd5,
        SUB_ACKH   = 4'd6,
        SUB_RXL    = 4'd7,
        SUB_RXH    = 4'd8,
        SUB_NACKL  = 4'd9,
        SUB_NACKH  = 4'd10,
        SUB_STOP1  = 4'd11,
        SUB_STOP2  = 4'd12,
        SUB_STOP3  = 4'd13
    } sub_t;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_WRITE,
        KIND_READ,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } out_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       busy;
        logic       scl;
        logic       sda;
        logic [3:0] bit_count;
    } back_status_t;

endpackage

FILE: hw/rtl/i2c_eeprom_master.sv
// Top level of the I2C EEPROM master: front queue, phase sequencer, result queue.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------
//   items in  | push / full        | item     (in_item_t)
//   results   | pop / empty        | res_item (out_item_t)
//   config    | cfg_we             | cfg_wdata (device address)
//
// One item per cycle sustained while the result queue has room; an item's result
// reaches the result ports through the front queue, then one sequencer step.
// The sequencer advances one bus phase per tick item it takes.
// Both queues hold two entries; a full result queue stalls the sequencer, which then
// lets the front queue fill and raise full.
// Reset: queues empty, bus lines released high, device address 80.
`include "assert_macros.svh"

module i2c_eeprom_master (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  iem_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output iem_pkg::out_item_t res_item,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata
);

    logic [6:0]            device_address_reg;
    logic                  q_valid;
    logic                  q_pop;
    iem_pkg::cmd_t         q_item;
    iem_pkg::back_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= iem_pkg::DEV_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            device_address_reg <= cfg_wdata;
        end
    end

    iem_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    iem_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .device_address (device_address_reg),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (q_item),
        .empty          (empty),
        .pop            (pop),
        .res_item       (res_item),
        .status         (status)
    );

    // idle sequencer leaves the bus released
    `IEM_ASSERT(a_idle_bus_free, clk, rst_n, !status.busy |-> (status.scl && status.sda))
    // a transfer in is always waiting for the sequencer next cycle
    `IEM_ASSERT(a_push_lands, clk, rst_n, (push && !full) |=> q_valid)
    // bit counter never passes one byte
    `IEM_ASSERT(a_bit_count, clk, rst_n, status.bit_count <= iem_pkg::BYTE_BITS)
    // the address only changes on a write
    `IEM_ASSERT(a_cfg_hold, clk, rst_n, !cfg_we |=> $stable(device_address_reg))

endmodule

FILE: hw/rtl/iem_front.sv
// Front end: classifies incoming items and holds them in a two-entry queue.
module iem_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  iem_pkg::in_item_t  item,
    output logic               q_valid,
    input  logic               q_pop,
    output iem_pkg::cmd_t      q_item
);

    iem_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    iem_pkg::cmd_t classified;
    logic          do_push;
    logic          do_pop;

    always_comb
    begin
        classified.mem_address = item.mem_address;
        classified.write_data  = item.write_data;
        classified.sda_in      = item.sda_in;
        case (item.op)
            iem_pkg::OP_TICK:  classified.kind = iem_pkg::KIND_TICK;
            iem_pkg::OP_WRITE: classified.kind = iem_pkg::KIND_WRITE;
            iem_pkg::OP_READ:  classified.kind = iem_pkg::KIND_READ;
            default:           classified.kind = iem_pkg::KIND_NOP;
        endcase
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

FILE: hw/rtl/iem_back.sv
// Back end: bus phase sequencer and two-entry result queue.
module iem_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [6:0]            device_address,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  iem_pkg::cmd_t         q_item,
    output logic                  empty,
    input  logic                  pop,
    output iem_pkg::out_item_t    res_item,
    output iem_pkg::back_status_t status
);

    logic [1:0]    seg_reg,      seg_next;
    iem_pkg::sub_t sub_reg,      sub_next;
    logic [3:0]    bit_count_reg, bit_count_next;
    logic [7:0]    shift_reg,    shift_next;
    logic          is_read_reg,  is_read_next;
    logic [7:0]    saved_addr_reg, saved_addr_next;
    logic [7:0]    saved_data_reg, saved_data_next;
    logic [7:0]    received_reg, received_next;
    logic          ack_reg,      ack_next;
    logic          scl_reg,      scl_next;
    logic          sda_reg,      sda_next;
    logic          fin;
    logic          idle;
    logic [3:0]    bit_inc;
    logic [7:0]    rx_shift;

    iem_pkg::out_item_t res_entry_reg [2];
    iem_pkg::out_item_t result;
    logic               res_wr_reg;
    logic               res_rd_reg;
    logic [1:0]         res_count_reg;
    logic               step;
    logic               res_pop;

    assign idle     = (seg_reg == iem_pkg::SEG_DEV) && (sub_reg == iem_pkg::SUB_IDLE);
    assign bit_inc  = bit_count_reg + 4'd1;
    assign rx_shift = {shift_reg[6:0], q_item.sda_in};
    assign step     = q_valid && (res_count_reg != 2'd2);
    assign q_pop    = step;

    always_comb
    begin
        seg_next        = seg_reg;
        sub_next        = sub_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        is_read_next    = is_read_reg;
        saved_addr_next = saved_addr_reg;
        saved_data_next = saved_data_reg;
        received_next   = received_reg;
        ack_next        = ack_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        fin             = 1'b0;
        case (q_item.kind)
            iem_pkg::KIND_TICK:
            begin
                case (sub_reg)
                    iem_pkg::SUB_IDLE:
                    begin
                    end
                    iem_pkg::SUB_START1:
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                        sub_next = iem_pkg::SUB_START2;
                    end
                    iem_pkg::SUB_START2:
                    begin
                        sda_next       = 1'b0;
                        shift_next     = {device_address, seg_reg == iem_pkg::SEG_DATA};
                        bit_count_next = 4'd0;
                        sub_next       = iem_pkg::SUB_TXL;
                    end
                    iem_pkg::SUB_TXL:
                    begin
                        scl_next = 1'b0;
                        sda_next = shift_reg[7];
                        sub_next = iem_pkg::SUB_TXH;
                    end
                    iem_pkg::SUB_TXH:
                    begin
                        scl_next       = 1'b1;
                        shift_next     = {shift_reg[6:0], 1'b0};
                        bit_count_next = bit_inc;
                        sub_next       = (bit_inc >= iem_pkg::BYTE_BITS) ?
                                         iem_pkg::SUB_ACKL : iem_pkg::SUB_TXL;
                    end
                    iem_pkg::SUB_ACKL, iem_pkg::SUB_RXL, iem_pkg::SUB_NACKL:
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b1;
                        case (sub_reg)
                            iem_pkg::SUB_ACKL: sub_next = iem_pkg::SUB_ACKH;
                            iem_pkg::SUB_RXL:  sub_next = iem_pkg::SUB_RXH;
                            default:           sub_next = iem_pkg::SUB_NACKH;
                        endcase
                    end
                    iem_pkg::SUB_ACKH:
                    begin
                        scl_next = 1'b1;
                        // memory-address acknowledge of a read goes unchecked
                        if (!(is_read_reg && seg_reg == iem_pkg::SEG_MEM))
                        begin
                            ack_next = q_item.sda_in;
                        end
                        if (seg_reg == iem_pkg::SEG_DEV)
                        begin
                            shift_next     = saved_addr_reg;
                            bit_count_next = 4'd0;
                            seg_next       = iem_pkg::SEG_MEM;
                            sub_next       = iem_pkg::SUB_TXL;
                        end
                        else if (seg_reg == iem_pkg::SEG_MEM)
                        begin
                            seg_next = iem_pkg::SEG_DATA;
                            if (is_read_reg)
                            begin
                                sub_next = iem_pkg::SUB_START1;
                            end
                            else
                            begin
                                shift_next     = saved_data_reg;
                                bit_count_next = 4'd0;
                                sub_next       = iem_pkg::SUB_TXL;
                            end
                        end
                        else if (is_read_reg)
                        begin
                            shift_next     = 8'd0;
                            bit_count_next = 4'd0;
                            seg_next       = iem_pkg::SEG_TAIL;
                            sub_next       = iem_pkg::SUB_RXL;
                        end
                        else
                        begin
                            seg_next = iem_pkg::SEG_TAIL;
                            sub_next = iem_pkg::SUB_STOP1;
                        end
                    end
                    iem_pkg::SUB_RXH:
                    begin
                        scl_next       = 1'b1;
                        shift_next     = rx_shift;
                        bit_count_next = bit_inc;
                        if (bit_inc >= iem_pkg::BYTE_BITS)
                        begin
                            received_next = rx_shift;
                            sub_next      = iem_pkg::SUB_NACKL;
                        end
                        else
                        begin
                            sub_next = iem_pkg::SUB_RXL;
                        end
                    end
                    iem_pkg::SUB_NACKH:
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                        sub_next = iem_pkg::SUB_STOP1;
                    end
                    iem_pkg::SUB_STOP1:
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                        sub_next = iem_pkg::SUB_STOP2;
                    end
                    iem_pkg::SUB_STOP2:
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b0;
                        sub_next = iem_pkg::SUB_STOP3;
                    end
                    iem_pkg::SUB_STOP3:
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                        seg_next = iem_pkg::SEG_DEV;
                        sub_next = iem_pkg::SUB_IDLE;
                        fin      = 1'b1;
                    end
                    default:
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                        seg_next = iem_pkg::SEG_DEV;
                        sub_next = iem_pkg::SUB_IDLE;
                    end
                endcase
            end
            iem_pkg::KIND_WRITE, iem_pkg::KIND_READ:
            begin
                // commands while busy are dropped
                if (idle)
                begin
                    saved_addr_next = q_item.mem_address;
                    saved_data_next = q_item.write_data;
                    is_read_next    = (q_item.kind == iem_pkg::KIND_READ);
                    bit_count_next  = 4'd0;
                    seg_next        = iem_pkg::SEG_DEV;
                    sub_next        = iem_pkg::SUB_START1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.scl_level   = scl_next;
        result.sda_release = sda_next;
        result.busy_res    = !((seg_next == iem_pkg::SEG_DEV) &&
                               (sub_next == iem_pkg::SUB_IDLE));
        result.done_res    = fin;
        result.read_data   = received_next;
        result.ack_missing = ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg        <= iem_pkg::SEG_DEV;
            sub_reg        <= iem_pkg::SUB_IDLE;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            is_read_reg    <= 1'b0;
            saved_addr_reg <= 8'd0;
            saved_data_reg <= 8'd0;
            received_reg   <= 8'd0;
            ack_reg        <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
        end
        else if (step)
        begin
            seg_reg        <= seg_next;
            sub_reg        <= sub_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            is_read_reg    <= is_read_next;
            saved_addr_reg <= saved_addr_next;
            saved_data_reg <= saved_data_next;
            received_reg   <= received_next;
            ack_reg        <= ack_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
        end
    end

    // result queue
    assign empty    = (res_count_reg == 2'd0);
    assign res_pop  = pop && !empty;
    assign res_item = res_entry_reg[res_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg    <= 1'b0;
            res_rd_reg    <= 1'b0;
            res_count_reg <= 2'd0;
        end
        else
        begin
            if (step && !res_pop)
            begin
                res_count_reg <= res_count_reg + 2'd1;
            end
            else if (res_pop && !step)
            begin
                res_count_reg <= res_count_reg - 2'd1;
            end
            if (step)
            begin
                res_wr_reg <= !res_wr_reg;
            end
            if (res_pop)
            begin
                res_rd_reg <= !res_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_entry_reg[res_wr_reg] <= result;
        end
    end

    assign status.busy      = !idle;
    assign status.scl       = scl_reg;
    assign status.sda       = sda_reg;
    assign status.bit_count = bit_count_reg;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the I2C EEPROM master: bus sequencer predictor, queued results.
module testbench;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int HOLD_CYCLES = 64;
    localparam int SETTLE = 4;
    localparam int QUIET_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    iem_pkg::in_item_t item;
    logic empty;
    logic pop;
    iem_pkg::out_item_t res_item;
    logic cfg_we;
    logic [6:0] cfg_wdata;

    i2c_eeprom_master uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .res_item(res_item),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // predicted bus sequencer state
    logic [6:0] dev_addr;
    logic [1:0] seg;
    iem_pkg::sub_t sub;
    logic [3:0] bit_cnt;
    logic [7:0] shifter;
    logic cmd_read;
    logic [7:0] cmd_addr;
    logic [7:0] cmd_data;
    logic [7:0] rx_byte;
    logic ack_seen;
    logic scl_q;
    logic sda_q;

    iem_pkg::out_item_t pending_lines[$];
    iem_pkg::out_item_t want_line;

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_writes_done = 0;
    int n_reads_done = 0;
    int n_addr_writes = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic bus_busy();
        return (seg != iem_pkg::SEG_DEV) || (sub != iem_pkg::SUB_IDLE);
    endfunction

    function automatic void load_byte(input logic [1:0] s, input logic [7:0] v);
        shifter = v;
        bit_cnt = '0;
        seg = s;
        sub = iem_pkg::SUB_TXL;
    endfunction

    // one bus phase; returns 1 when the stop condition completes
    function automatic logic advance_bus(input logic sda_in);
        logic fin;
        fin = 1'b0;
        case (sub)
            iem_pkg::SUB_IDLE: ;
            iem_pkg::SUB_START1:
            begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                sub = iem_pkg::SUB_START2;
            end
            iem_pkg::SUB_START2:
            begin
                sda_q = 1'b0;
                load_byte(seg, {dev_addr, seg == iem_pkg::SEG_DATA});
            end
            iem_pkg::SUB_TXL:
            begin
                scl_q = 1'b0;
                sda_q = shifter[7];
                sub = iem_pkg::SUB_TXH;
            end
            iem_pkg::SUB_TXH:
            begin
                scl_q = 1'b1;
                shifter = {shifter[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                sub = (bit_cnt >= iem_pkg::BYTE_BITS) ? iem_pkg::SUB_ACKL : iem_pkg::SUB_TXL;
            end
            iem_pkg::SUB_ACKL, iem_pkg::SUB_RXL, iem_pkg::SUB_NACKL:
            begin
                scl_q = 1'b0;
                sda_q = 1'b1;
                sub = iem_pkg::sub_t'(sub + 4'd1);
            end
            iem_pkg::SUB_ACKH:
            begin
                scl_q = 1'b1;
                // memory-address acknowledge of a read goes unchecked
                if (!(cmd_read && seg == iem_pkg::SEG_MEM))
                    ack_seen = sda_in;
                if (seg == iem_pkg::SEG_DEV)
                    load_byte(iem_pkg::SEG_MEM, cmd_addr);
                else if (seg == iem_pkg::SEG_MEM)
                begin
                    if (cmd_read)
                    begin
                        seg = iem_pkg::SEG_DATA;
                        sub = iem_pkg::SUB_START1;
                    end
                    else
                        load_byte(iem_pkg::SEG_DATA, cmd_data);
                end
                else if (cmd_read)
                begin
                    shifter = '0;
                    bit_cnt = '0;
                    seg = iem_pkg::SEG_TAIL;
                    sub = iem_pkg::SUB_RXL;
                end
                else
                begin
                    seg = iem_pkg::SEG_TAIL;
                    sub = iem_pkg::SUB_STOP1;
                end
            end
            iem_pkg::SUB_RXH:
            begin
                scl_q = 1'b1;
                shifter = {shifter[6:0], sda_in};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= iem_pkg::BYTE_BITS)
                begin
                    rx_byte = shifter;
                    sub = iem_pkg::SUB_NACKL;
                end
                else
                    sub = iem_pkg::SUB_RXL;
            end
            iem_pkg::SUB_NACKH:
            begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                sub = iem_pkg::SUB_STOP1;
            end
            iem_pkg::SUB_STOP1:
            begin
                scl_q = 1'b0;
                sda_q = 1'b0;
                sub = iem_pkg::SUB_STOP2;
            end
            iem_pkg::SUB_STOP2:
            begin
                scl_q = 1'b1;
                sda_q = 1'b0;
                sub = iem_pkg::SUB_STOP3;
            end
            iem_pkg::SUB_STOP3:
            begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                seg = iem_pkg::SEG_DEV;
                sub = iem_pkg::SUB_IDLE;
                fin = 1'b1;
            end
            default:
            begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                seg = iem_pkg::SEG_DEV;
                sub = iem_pkg::SUB_IDLE;
            end
        endcase
        return fin;
    endfunction

    function automatic iem_pkg::out_item_t step_bus_model(input iem_pkg::in_item_t it);
        iem_pkg::out_item_t r;
        logic fin;
        fin = 1'b0;
        if (it.op == iem_pkg::OP_TICK)
            fin = advance_bus(it.sda_in);
        else if ((it.op == iem_pkg::OP_WRITE || it.op == iem_pkg::OP_READ) && !bus_busy())
        begin
            cmd_addr = it.mem_address;
            cmd_data = it.write_data;
            cmd_read = (it.op == iem_pkg::OP_READ);
            bit_cnt = '0;
            seg = iem_pkg::SEG_DEV;
            sub = iem_pkg::SUB_START1;
        end
        if (fin)
        begin
            if (cmd_read)
                n_reads_done++;
            else
                n_writes_done++;
        end
        r.scl_level = scl_q;
        r.sda_release = sda_q;
        r.busy_res = bus_busy();
        r.done_res = fin;
        r.read_data = rx_byte;
        r.ack_missing = ack_seen;
        return r;
    endfunction

    function automatic iem_pkg::in_item_t make_item(input logic [1:0] op,
                                                    input logic [7:0] a,
                                                    input logic [7:0] d, input logic s);
        iem_pkg::in_item_t r;
        r.op = op;
        r.mem_address = a;
        r.write_data = d;
        r.sda_in = s;
        return r;
    endfunction

    function automatic iem_pkg::in_item_t random_item(input logic [1:0] op);
        return make_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input iem_pkg::in_item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_lines.push_back(step_bus_model(it));
        n_items++;
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_lines.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_device_address(input logic [6:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        dev_addr = v;
        n_addr_writes++;
    endtask

    task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
    endtask

    task automatic test_idle_items();
        send_item(make_item(iem_pkg::OP_TICK, 8'h00, 8'h00, 1'b0));
        send_item(make_item(iem_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1));
        send_item(make_item(OP_NOP, 8'hFF, 8'hFF, 1'b1));
        drain();
    endtask

    // commands and no-ops mid-transaction are dropped; an address change mid-transaction
    // takes effect at the next address byte loaded
    task automatic test_command_while_busy();
        send_item(make_item(iem_pkg::OP_WRITE, 8'hFF, 8'h00, 1'b1));
        send_item(make_item(iem_pkg::OP_READ, 8'h00, 8'hFF, 1'b0));
        send_item(make_item(OP_NOP, 8'h55, 8'hAA, 1'b0));
        send_item(make_item(iem_pkg::OP_TICK, 8'h00, 8'h00, 1'b0));
        drain();
        write_device_address(7'd0);
        send_item(make_item(iem_pkg::OP_TICK, 8'h00, 8'h00, 1'b1));
        send_item(make_item(iem_pkg::OP_TICK, 8'h00, 8'h00, 1'b0));
        drain();
    endtask

    // well-formed transactions with random content, a little noise mixed in
    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int budget);
        int sent;
        int pick;
        logic [1:0] op;
        sender_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        sent = 0;
        while (sent < budget || bus_busy())
        begin
            pick = $urandom_range(99);
            if (!bus_busy())
                op = (pick < 45) ? iem_pkg::OP_WRITE : (pick < 90) ? iem_pkg::OP_READ :
                     (pick < 95) ? iem_pkg::OP_TICK : OP_NOP;
            else if (sent < budget && pick < 6)
                op = (pick < 2) ? iem_pkg::OP_WRITE : (pick < 4) ? iem_pkg::OP_READ : OP_NOP;
            else
                op = iem_pkg::OP_TICK;
            send_item(random_item(op));
            sent++;
        end
        drain();
    endtask

    // receiver holds off long enough for both queues to fill and full to rise
    task automatic test_backpressure();
        hold_asks <= hold_asks + 1;
        run_random_phase(0, 0, 30);
    endtask

    // result side: random stalls plus requested hold-offs
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_lines.size() == 0)
            begin
                $display("%0t: result transfer with nothing predicted, got %h", $time, res_item);
                errors++;
            end
            else
            begin
                want_line = pending_lines.pop_front();
                n_results++;
                if (res_item.scl_level !== want_line.scl_level)
                    report_field("scl_level", 8'(want_line.scl_level),
                                 8'(res_item.scl_level));
                if (res_item.sda_release !== want_line.sda_release)
                    report_field("sda_release", 8'(want_line.sda_release),
                                 8'(res_item.sda_release));
                if (res_item.busy_res !== want_line.busy_res)
                    report_field("busy_res", 8'(want_line.busy_res), 8'(res_item.busy_res));
                if (res_item.done_res !== want_line.done_res)
                    report_field("done_res", 8'(want_line.done_res), 8'(res_item.done_res));
                if (res_item.read_data !== want_line.read_data)
                    report_field("read_data", want_line.read_data, res_item.read_data);
                if (res_item.ack_missing !== want_line.ack_missing)
                    report_field("ack_missing", 8'(want_line.ack_missing),
                                 8'(res_item.ack_missing));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we)
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        dev_addr = iem_pkg::DEV_ADDR_RESET;
        seg = iem_pkg::SEG_DEV;
        sub = iem_pkg::SUB_IDLE;
        bit_cnt = '0;
        shifter = '0;
        cmd_read = 1'b0;
        cmd_addr = '0;
        cmd_data = '0;
        rx_byte = '0;
        ack_seen = 1'b0;
        scl_q = 1'b1;
        sda_q = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_items();
        test_command_while_busy();
        run_random_phase(0, 0, 60);
        write_device_address(7'd127);
        test_backpressure();
        write_device_address(7'($urandom_range(126, 1)));
        run_random_phase(76, 0, 60);
        run_random_phase(0, 76, 60);
        write_device_address(iem_pkg::DEV_ADDR_RESET);
        run_random_phase(37, 37, 60);

        repeat (SETTLE) @(negedge clk);
        $display("Covered %0d items and %0d results under four idling mixes and one long hold-off;",
                 n_items, n_results);
        $display("%0d byte writes and %0d random reads ran to the stop, %0d address settings.",
                 n_writes_done, n_reads_done, n_addr_writes);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
